>>> src/vcomdc_pkg.sv
`default_nettype none

package vcomdc_pkg;

    // Error codes carried with every result.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;

    // Conversion direction.
    localparam logic OP_MV_TO_CODE = 1'b0;
    localparam logic OP_CODE_TO_MV = 1'b1;

    // Register indexes (word address bits of paddr).
    localparam logic [2:0] REG_CODE_SPAN    = 3'd0;
    localparam logic [2:0] REG_VOLT_SPAN    = 3'd1;
    localparam logic [2:0] REG_VOLT_OFFSET  = 3'd2;
    localparam logic [2:0] REG_ACTUAL_SWING = 3'd3;
    localparam logic [2:0] REG_IDEAL_SWING  = 3'd4;

    // Saturation limits of the result field.
    localparam logic signed [31:0] RESULT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RESULT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               op;
        logic signed [15:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         error;
    } t_out_beat;

    // Side information that rides through the first divider.
    typedef struct packed {
        logic op;
        logic neg;
        logic zero;
    } t_div1_tag;

    // Side information that rides through the second divider.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_div2_tag;

endpackage

`default_nettype wire

>>> src/vcomdc_div.sv
`default_nettype none

// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
module vcomdc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int TAG_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output logic [NUM_W-1:0]        o_quo,
    output logic [TAG_W-1:0]        o_tag
);

    localparam int WORD_W = DEN_W + NUM_W;

    // Each word holds the partial remainder above the numerator bits still
    // to be consumed; quotient bits shift in at the bottom.
    logic               r_vld  [NUM_W];
    logic [WORD_W-1:0]  r_word [NUM_W];
    logic [DEN_W-1:0]   r_den  [NUM_W];
    logic [TAG_W-1:0]   r_tag  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              vld_in;
        logic [WORD_W-1:0] word_in;
        logic [DEN_W-1:0]  den_in;
        logic [TAG_W-1:0]  tag_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [WORD_W-1:0] n_word;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign word_in = {{DEN_W{1'b0}}, i_num};
            assign den_in  = i_den;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign word_in = r_word[k-1];
            assign den_in  = r_den[k-1];
            assign tag_in  = r_tag[k-1];
        end

        assign trial  = word_in[WORD_W-1 -: DEN_W+1];
        assign diff   = trial - {1'b0, den_in};
        assign ge     = (trial >= {1'b0, den_in});
        assign n_word = {(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]),
                         word_in[NUM_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_word[k] <= n_word;
            r_den[k]  <= den_in;
            r_tag[k]  <= tag_in;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_word[NUM_W-1][NUM_W-1:0];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

`default_nettype wire

>>> src/vcom_dac_conversion.sv
// A command passes the input register, the first divider, the intercept and product
// registers, the operand register, the second divider and the output register.
// Throughput: one command per cycle; busy never rises, since every stage moves on each cycle.
// The two bit-serial divider pipelines (32 and 49 stages) set the latency.
// Reset (i_rst_n low at a clock edge) clears all valid bits and loads the
// calibration registers with their defaults. The receiver cannot stall.
`default_nettype none

module vcom_dac_conversion (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire vcomdc_pkg::t_in_beat   i_in_beat,
    output logic                        o_valid,
    output vcomdc_pkg::t_out_beat       o_out_beat,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Quotient widths of the two dividers. The first quotient stays below
    // 2^32; the second dividend stays below 2^49 for every register pattern.
    localparam int DEN_W = 17;
    localparam int Q1_W  = 32;
    localparam int Q2_W  = 49;
    localparam int LAT   = Q1_W + Q2_W + 5;

    // ------------------------------------------------------------------
    // Calibration registers on the APB port. Writes complete in the access
    // cycle; reads return the sign-extended register value.
    // ------------------------------------------------------------------
    logic signed [12:0] r_code_span;
    logic signed [16:0] r_volt_span;
    logic signed [20:0] r_volt_offset;
    logic signed [16:0] r_actual_swing;
    logic signed [16:0] r_ideal_swing;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_span    <= 13'sd1;
            r_volt_span    <= 17'sd1;
            r_volt_offset  <= 21'sd0;
            r_actual_swing <= 17'sd1;
            r_ideal_swing  <= 17'sd1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                vcomdc_pkg::REG_CODE_SPAN:    r_code_span    <= pwdata[12:0];
                vcomdc_pkg::REG_VOLT_SPAN:    r_volt_span    <= pwdata[16:0];
                vcomdc_pkg::REG_VOLT_OFFSET:  r_volt_offset  <= pwdata[20:0];
                vcomdc_pkg::REG_ACTUAL_SWING: r_actual_swing <= pwdata[16:0];
                vcomdc_pkg::REG_IDEAL_SWING:  r_ideal_swing  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            vcomdc_pkg::REG_CODE_SPAN:    prdata = 32'(r_code_span);
            vcomdc_pkg::REG_VOLT_SPAN:    prdata = 32'(r_volt_span);
            vcomdc_pkg::REG_VOLT_OFFSET:  prdata = 32'(r_volt_offset);
            vcomdc_pkg::REG_ACTUAL_SWING: prdata = 32'(r_actual_swing);
            vcomdc_pkg::REG_IDEAL_SWING:  prdata = 32'(r_ideal_swing);
            default:                      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // First stage: value times the first factor, divisor selection and the
    // zero-divisor check. For millivolts to code the factor is the actual
    // swing over the ideal swing; for code to millivolts it is the voltage
    // span over the code span. Toward a code, rounding to nearest adds half
    // the divisor to the magnitude before a truncating divide.
    // ------------------------------------------------------------------
    logic                        acc;
    logic                        b_op;
    logic signed [16:0]          b_mul;
    logic signed [16:0]          b_den;
    logic signed [32:0]          b_prod;
    logic [32:0]                 b_pmag;
    logic [DEN_W-1:0]            b_dmag;
    logic [Q1_W-1:0]             b_num;
    logic                        b_zero;
    vcomdc_pkg::t_div1_tag       b_tag;

    assign acc    = start && !busy;
    assign b_op   = i_in_beat.op;
    assign b_mul  = (b_op == vcomdc_pkg::OP_CODE_TO_MV) ? r_volt_span : r_actual_swing;
    assign b_den  = (b_op == vcomdc_pkg::OP_CODE_TO_MV) ? 17'(r_code_span) : r_ideal_swing;
    assign b_zero = (b_op == vcomdc_pkg::OP_CODE_TO_MV)
                  ? (r_code_span == 13'sd0 || r_actual_swing == 17'sd0)
                  : (r_ideal_swing == 17'sd0 || r_volt_span == 17'sd0);
    assign b_prod = 33'(i_in_beat.value) * 33'(b_mul);
    assign b_pmag = b_prod[32] ? (33'd0 - b_prod) : b_prod;
    assign b_dmag = b_den[16] ? (17'd0 - b_den) : b_den;

    always_comb begin
        b_num = b_pmag[Q1_W-1:0];
        if (b_op == vcomdc_pkg::OP_MV_TO_CODE) begin
            b_num = b_pmag[Q1_W-1:0] + Q1_W'(b_dmag >> 1);
        end
        b_tag.op   = b_op;
        b_tag.neg  = b_prod[32] ^ b_den[16];
        b_tag.zero = b_zero;
    end

    logic                   r_b_vld;
    logic [Q1_W-1:0]        r_b_num;
    logic [DEN_W-1:0]       r_b_den;
    vcomdc_pkg::t_div1_tag  r_b_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= acc;
        end
    end

    // A zero divisor is replaced by one so the divider does something sane;
    // the result is overridden at the end anyway.
    always_ff @(posedge i_clk) begin
        r_b_num <= b_num;
        r_b_den <= b_zero ? DEN_W'(1) : b_dmag;
        r_b_tag <= b_tag;
    end

    logic                   d1_vld;
    logic [Q1_W-1:0]        d1_quo;
    vcomdc_pkg::t_div1_tag  d1_tag;

    vcomdc_div #(
        .NUM_W (Q1_W),
        .DEN_W (DEN_W),
        .TAG_W ($bits(vcomdc_pkg::t_div1_tag))
    ) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_tag   (r_b_tag),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    // ------------------------------------------------------------------
    // Restore the sign of the first quotient and apply the voltage
    // intercept: subtracted before the code conversion, added after the
    // millivolt conversion.
    // ------------------------------------------------------------------
    logic signed [33:0] c_q;
    logic signed [33:0] c_x;

    assign c_q = d1_tag.neg ? (34'sd0 - 34'({2'b00, d1_quo})) : 34'({2'b00, d1_quo});
    assign c_x = (d1_tag.op == vcomdc_pkg::OP_CODE_TO_MV)
               ? c_q + 34'(r_volt_offset)
               : c_q - 34'(r_volt_offset);

    logic               r_c_vld;
    logic signed [33:0] r_c_x;
    logic               r_c_op;
    logic               r_c_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_x    <= c_x;
        r_c_op   <= d1_tag.op;
        r_c_zero <= d1_tag.zero;
    end

    // ------------------------------------------------------------------
    // Second product: times the code span toward a code, times the ideal
    // swing toward millivolts.
    // ------------------------------------------------------------------
    logic signed [16:0] d_mul;
    logic signed [50:0] d_prod;

    assign d_mul  = (r_c_op == vcomdc_pkg::OP_CODE_TO_MV) ? r_ideal_swing : 17'(r_code_span);
    assign d_prod = 51'(r_c_x) * 51'(d_mul);

    logic               r_d_vld;
    logic signed [50:0] r_d_prod;
    logic               r_d_op;
    logic               r_d_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_prod <= d_prod;
        r_d_op   <= r_c_op;
        r_d_zero <= r_c_zero;
    end

    // ------------------------------------------------------------------
    // Magnitudes for the second divide, with the rounding bias again for
    // the code direction.
    // ------------------------------------------------------------------
    logic signed [16:0]     e_den;
    logic [50:0]            e_pmag;
    logic [DEN_W-1:0]       e_dmag;
    logic [Q2_W-1:0]        e_num;
    vcomdc_pkg::t_div2_tag  e_tag;

    assign e_den  = (r_d_op == vcomdc_pkg::OP_CODE_TO_MV) ? r_actual_swing : r_volt_span;
    assign e_pmag = r_d_prod[50] ? (51'd0 - r_d_prod) : r_d_prod;
    assign e_dmag = e_den[16] ? (17'd0 - e_den) : e_den;

    always_comb begin
        e_num = e_pmag[Q2_W-1:0];
        if (r_d_op == vcomdc_pkg::OP_MV_TO_CODE) begin
            e_num = e_pmag[Q2_W-1:0] + Q2_W'(e_dmag >> 1);
        end
        e_tag.neg  = r_d_prod[50] ^ e_den[16];
        e_tag.zero = r_d_zero;
    end

    logic                   r_e_vld;
    logic [Q2_W-1:0]        r_e_num;
    logic [DEN_W-1:0]       r_e_den;
    vcomdc_pkg::t_div2_tag  r_e_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_num <= e_num;
        r_e_den <= (e_dmag == DEN_W'(0)) ? DEN_W'(1) : e_dmag;
        r_e_tag <= e_tag;
    end

    logic                   d2_vld;
    logic [Q2_W-1:0]        d2_quo;
    vcomdc_pkg::t_div2_tag  d2_tag;

    vcomdc_div #(
        .NUM_W (Q2_W),
        .DEN_W (DEN_W),
        .TAG_W ($bits(vcomdc_pkg::t_div2_tag))
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_tag   (r_e_tag),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag)
    );

    // ------------------------------------------------------------------
    // Final sign, saturation to 32 bits and error coding. A zero divisor
    // wins over saturation and forces a zero result.
    // ------------------------------------------------------------------
    logic signed [Q2_W:0]   f_q;
    vcomdc_pkg::t_out_beat  f_beat;

    assign f_q = d2_tag.neg ? ((Q2_W+1)'(0) - (Q2_W+1)'(d2_quo)) : (Q2_W+1)'(d2_quo);

    always_comb begin
        f_beat.result = f_q[31:0];
        f_beat.error  = vcomdc_pkg::ERR_OK;
        if (d2_tag.zero) begin
            f_beat.result = 32'sd0;
            f_beat.error  = vcomdc_pkg::ERR_ZERO;
        end else if (f_q > (Q2_W+1)'(vcomdc_pkg::RESULT_MAX)) begin
            f_beat.result = vcomdc_pkg::RESULT_MAX;
            f_beat.error  = vcomdc_pkg::ERR_SAT;
        end else if (f_q < (Q2_W+1)'(vcomdc_pkg::RESULT_MIN)) begin
            f_beat.result = vcomdc_pkg::RESULT_MIN;
            f_beat.error  = vcomdc_pkg::ERR_SAT;
        end
    end

    logic                  r_out_vld;
    vcomdc_pkg::t_out_beat r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= f_beat;
    end

    assign o_valid    = r_out_vld;
    assign o_out_beat = r_out_beat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every accepted command yields its result beat after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result beat missing after accepted command");

    // A beat with no command in flight would be an invented result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result beat without an accepted command");

    // A saturated result sits exactly on one of the two limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_beat.error == vcomdc_pkg::ERR_SAT) |->
        (o_out_beat.result == vcomdc_pkg::RESULT_MAX ||
         o_out_beat.result == vcomdc_pkg::RESULT_MIN))
        else $error("saturated result not at a limit");

    // A zero divisor reports a zero result.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_beat.error == vcomdc_pkg::ERR_ZERO) |->
        (o_out_beat.result == 32'sd0))
        else $error("zero-divisor error with nonzero result");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the millivolt / DAC code converter.
// Commands go in through a driver that is fed from a queue. A monitor
// predicts every accepted beat and checks the strobed results in order.
// Calibration registers are rewritten over the APB port between phases,
// and only while nothing is in flight.
module testbench;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    vcomdc_pkg::t_in_beat  cmd_beat;
    logic                  o_valid;
    vcomdc_pkg::t_out_beat o_out_beat;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [4:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    vcom_dac_conversion uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in_beat (cmd_beat),
        .o_valid   (o_valid),
        .o_out_beat(o_out_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // The calibration that the bench believes the block holds.
    logic signed [12:0] cal_code_span;
    logic signed [16:0] cal_volt_span;
    logic signed [20:0] cal_volt_offset;
    logic signed [16:0] cal_actual_swing;
    logic signed [16:0] cal_ideal_swing;

    vcomdc_pkg::t_in_beat  pending_cmds[$];
    vcomdc_pkg::t_out_beat expected_results[$];
    int        error_count;
    int        result_count;
    int        sat_count;
    int        zero_count;
    int        gap_left;
    bit        cmd_taken;
    bit        no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous ceiling: the slowest correct run stays far below it.
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Signed division on magnitudes, either truncating or rounding half away
    // from zero, with the sign applied afterward.
    function automatic longint divide(input longint n, input longint d, input bit nearest);
        longint an;
        longint ad;
        longint q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = nearest ? (an + ad / 2) / ad : an / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic vcomdc_pkg::t_out_beat convert(input vcomdc_pkg::t_in_beat b);
        vcomdc_pkg::t_out_beat o;
        longint    v;
        longint    s;
        longint    r;
        v = longint'(b.value);
        r = 0;
        o.error = vcomdc_pkg::ERR_OK;
        if (b.op == vcomdc_pkg::OP_MV_TO_CODE) begin
            // The ideal swing divisor is checked before the voltage span.
            if (cal_ideal_swing == 0 || cal_volt_span == 0) begin
                o.error = vcomdc_pkg::ERR_ZERO;
            end else begin
                s = divide(v * longint'(cal_actual_swing), longint'(cal_ideal_swing), 1'b1);
                r = divide((s - longint'(cal_volt_offset)) * longint'(cal_code_span),
                           longint'(cal_volt_span), 1'b1);
            end
        end else begin
            if (cal_code_span == 0 || cal_actual_swing == 0) begin
                o.error = vcomdc_pkg::ERR_ZERO;
            end else begin
                s = divide(v * longint'(cal_volt_span), longint'(cal_code_span), 1'b0)
                    + longint'(cal_volt_offset);
                r = divide(s * longint'(cal_ideal_swing), longint'(cal_actual_swing), 1'b0);
            end
        end
        // Only the final value saturates; intermediate values stay exact.
        if (o.error == vcomdc_pkg::ERR_OK && r > longint'(vcomdc_pkg::RESULT_MAX)) begin
            r = longint'(vcomdc_pkg::RESULT_MAX);
            o.error = vcomdc_pkg::ERR_SAT;
        end else if (o.error == vcomdc_pkg::ERR_OK && r < longint'(vcomdc_pkg::RESULT_MIN)) begin
            r = longint'(vcomdc_pkg::RESULT_MIN);
            o.error = vcomdc_pkg::ERR_SAT;
        end
        o.result = r[31:0];
        return o;
    endfunction

    // Driver: a new command is presented at the falling edge once the previous
    // beat has been taken and the drawn gap has run out. start is computed
    // once per edge so it never drops and rises in the same step.
    always @(negedge i_clk) begin
        logic nxt_start;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && cmd_taken) begin
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    cmd_beat <= pending_cmds.pop_front();
                    nxt_start = 1'b1;
                    gap_left = no_gaps ? 0 : $urandom_range(0, 6);
                end
            end
        end
        start <= nxt_start;
    end

    // Monitor: predicts accepted commands and checks every strobed result.
    always @(posedge i_clk) begin
        vcomdc_pkg::t_out_beat want;
        cmd_taken = i_rst_n && start && !busy;
        if (cmd_taken) begin
            expected_results.push_back(convert(cmd_beat));
        end
        if (i_rst_n && o_valid) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result %0d error %0d",
                                 o_out_beat.result, o_out_beat.error));
            end else begin
                want = expected_results.pop_front();
                if (want.error == vcomdc_pkg::ERR_SAT) sat_count++;
                if (want.error == vcomdc_pkg::ERR_ZERO) zero_count++;
                if (o_out_beat.result !== want.result) begin
                    report($sformatf("result %0d, expected %0d",
                                     o_out_beat.result, want.result));
                end
                if (o_out_beat.error !== want.error) begin
                    report($sformatf("error code %0d, expected %0d",
                                     o_out_beat.error, want.error));
                end
            end
        end
    end

    // One APB write with setup and access cycles, then a read back of the
    // same register. The bench copy of the register changes at the write edge.
    task automatic reg_write(input logic [2:0] idx, input longint val);
        logic [31:0] mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val[31:0];
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            vcomdc_pkg::REG_CODE_SPAN:    cal_code_span    = val[12:0];
            vcomdc_pkg::REG_VOLT_SPAN:    cal_volt_span    = val[16:0];
            vcomdc_pkg::REG_VOLT_OFFSET:  cal_volt_offset  = val[20:0];
            vcomdc_pkg::REG_ACTUAL_SWING: cal_actual_swing = val[16:0];
            vcomdc_pkg::REG_IDEAL_SWING:  cal_ideal_swing  = val[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            vcomdc_pkg::REG_CODE_SPAN:    mask = 32'h1FFF;
            vcomdc_pkg::REG_VOLT_OFFSET:  mask = 32'h1F_FFFF;
            default:                      mask = 32'h1_FFFF;
        endcase
        if ((prdata & mask) !== (val[31:0] & mask)) begin
            report($sformatf("register %0d reads %h, wrote %h", idx, prdata, val[31:0]));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_cal(input longint cs, input longint vs, input longint vo,
                           input longint asw, input longint isw);
        reg_write(vcomdc_pkg::REG_CODE_SPAN, cs);
        reg_write(vcomdc_pkg::REG_VOLT_SPAN, vs);
        reg_write(vcomdc_pkg::REG_VOLT_OFFSET, vo);
        reg_write(vcomdc_pkg::REG_ACTUAL_SWING, asw);
        reg_write(vcomdc_pkg::REG_IDEAL_SWING, isw);
    endtask

    // Waits until every queued command is taken and every result is back.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_cmd(input logic op, input int val);
        vcomdc_pkg::t_in_beat b;
        b.op = op;
        b.value = val[15:0];
        pending_cmds.push_back(b);
    endtask

    // Picks a register value: extremes, zero, small or fully random.
    function automatic longint pick(input longint lo, input longint hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return 0;
            3: return $urandom_range(0, 1) ? 1 : -1;
            4, 5: return longint'($urandom_range(0, 200)) - 100;
            default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
        endcase
    endfunction

    task automatic queue_edges();
        int edge_vals[6] = '{-32768, 32767, 0, 1, -1, 3};
        foreach (edge_vals[k]) begin
            queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, edge_vals[k]);
            queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, edge_vals[k]);
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        start   = 1'b0;
        cmd_beat = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        result_count = 0;
        sat_count = 0;
        zero_count = 0;
        gap_left = 0;
        cmd_taken = 1'b0;
        no_gaps = 1'b0;
        cal_code_span = 13'sd1;
        cal_volt_span = 17'sd1;
        cal_volt_offset = 21'sd0;
        cal_actual_swing = 17'sd1;
        cal_ideal_swing = 17'sd1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: the reset calibration passes values straight through.
        queue_edges();
        drain();

        // Half ratios make the first rounding land on exact ties.
        set_cal(1, 1, 0, 1, 2);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, 1);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, -1);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, 5);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, -5);
        queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, 7);
        queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, -7);
        drain();

        // Largest gain in both directions drives the result into saturation.
        set_cal(4095, 1, -1048576, 65535, 1);
        queue_edges();
        drain();
        set_cal(1, 65535, 1048575, 1, 65535);
        queue_edges();
        drain();

        // Zero divisors: all at once, then the voltage span alone, then the code span alone.
        set_cal(0, 0, 5, 0, 0);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, 100);
        queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, 100);
        drain();
        set_cal(-4095, 0, 5, -65535, 7);
        queue_cmd(vcomdc_pkg::OP_MV_TO_CODE, 100);
        queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, 100);
        drain();
        set_cal(0, -65535, 5, -65535, 7);
        queue_cmd(vcomdc_pkg::OP_CODE_TO_MV, -100);
        drain();

        // Random phases: new calibration, then a batch of random commands.
        // Some phases run with no gaps so the pipeline fills back to back.
        for (int ph = 0; ph < 14; ph++) begin
            set_cal(pick(-4095, 4095), pick(-65535, 65535), pick(-1048576, 1048575),
                    pick(-65535, 65535), pick(-65535, 65535));
            no_gaps = ($urandom_range(0, 3) == 0);
            n = 100;
            repeat (n) begin
                queue_cmd($urandom_range(0, 1),
                          ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 32767 : -32768)
                                                      : int'($urandom_range(0, 65535)) - 32768);
            end
            drain();
        end
        no_gaps = 1'b0;

        repeat (100) @(posedge i_clk);
        $display("Checked %0d conversions over 21 calibration settings.", result_count);
        $display("Saturated results: %0d, zero-divisor results: %0d.", sat_count, zero_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
